/* rtl/core/swc_pkg.sv */
`timescale 1ns / 1ps

package swc_pkg;

    // Image height; rows at or beyond it carry no weight.
    localparam int ROWS = 120;

    localparam int ROW_W    = 7;
    localparam int COL_W    = 8;
    localparam int WEIGHT_W = 5;
    localparam int SUM_W    = 19;
    localparam int TOTAL_W  = 12;
    localparam int LIM_W    = 7;
    localparam int ERR_W    = 8;

    // Product of the center column and the weight total.
    localparam int PROD_W = COL_W + TOTAL_W;
    // Magnitude of the signed numerator handed to the divider.
    localparam int DVD_W  = PROD_W + 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [COL_W-1:0] CENTER_RESET = 8'd80;
    localparam logic [LIM_W-1:0] LIMIT_RESET  = 7'd80;
    localparam logic [LIM_W-1:0] SLEW_RESET   = 7'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER = 2'd0,
        REG_LIMIT  = 2'd1,
        REG_SLEW   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic acc_en;
        logic clear;
    } acc_ctrl_t;

    // Row band weights, in tenths.
    function automatic logic [WEIGHT_W-1:0] band_weight(input logic [ROW_W-1:0] row);
        logic [WEIGHT_W-1:0] w;
        if ({2'b00, row} >= 9'(ROWS)) begin
            w = 5'd0;
        end else if (row < 7'd40) begin
            w = 5'd0;
        end else if (row < 7'd60) begin
            w = 5'd10;
        end else if (row < 7'd70) begin
            w = 5'd13;
        end else if (row < 7'd80) begin
            w = 5'd18;
        end else if (row < 7'd110) begin
            w = 5'd25;
        end else begin
            w = 5'd0;
        end
        return w;
    endfunction

endpackage

/* rtl/core/swc_accum.sv */
`timescale 1ns / 1ps

module swc_accum (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  swc_pkg::acc_ctrl_t            ctrl,
    input  logic [swc_pkg::ROW_W-1:0]     row_index,
    input  logic [swc_pkg::COL_W-1:0]     midline_col,
    output logic [swc_pkg::SUM_W-1:0]     sum,
    output logic [swc_pkg::TOTAL_W-1:0]   total
);
    import swc_pkg::*;

    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [TOTAL_W-1:0]       total_reg, total_next;
    logic [WEIGHT_W-1:0]      weight;
    logic [WEIGHT_W+COL_W-1:0] term;
    logic [SUM_W:0]           sum_wide;
    logic [TOTAL_W:0]         total_wide;

    always_comb begin
        weight     = band_weight(row_index);
        term       = weight * midline_col;
        sum_wide   = {1'b0, sum_reg} + (SUM_W+1)'(term);
        total_wide = {1'b0, total_reg} + (TOTAL_W+1)'(weight);
        sum_next   = sum_reg;
        total_next = total_reg;
        if (ctrl.clear) begin
            sum_next   = '0;
            total_next = '0;
        end else if (ctrl.acc_en) begin
            // Both sums saturate when a frame repeats rows.
            sum_next   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            total_next = total_wide[TOTAL_W] ? '1 : total_wide[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            total_reg <= '0;
        end else begin
            sum_reg   <= sum_next;
            total_reg <= total_next;
        end
    end

    assign sum   = sum_reg;
    assign total = total_reg;

endmodule

/* rtl/core/swc_divider.sv */
`timescale 1ns / 1ps

module swc_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [swc_pkg::DVD_W-1:0]     dividend,
    input  logic [swc_pkg::TOTAL_W-1:0]   divisor,
    output logic                          done,
    output logic [swc_pkg::DVD_W-1:0]     quotient
);
    import swc_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TOTAL_W-1:0]   rem_reg, rem_next;
    logic [TOTAL_W-1:0]   div_reg, div_next;
    logic [DVD_W-1:0]     quot_reg, quot_next;
    logic [TOTAL_W:0]     trial;
    logic                 fits;

    // Restoring division, one quotient bit per cycle. The dividend shifts
    // out of the top of quot_reg while quotient bits shift in at the bottom.
    always_comb begin
        trial      = {rem_reg, quot_reg[DVD_W-1]};
        fits       = trial >= {1'b0, div_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quot_next  = quot_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = '0;
            div_next   = divisor;
            quot_next  = dividend;
        end else if (busy_reg) begin
            rem_next   = fits ? TOTAL_W'(trial - {1'b0, div_reg}) : trial[TOTAL_W-1:0];
            quot_next  = {quot_reg[DVD_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

/* rtl/core/steering_error_weighted_centroid.sv */
`timescale 1ns / 1ps
// Channel   Direction  Payload (lowest bit up)
// s_axis    in         tdata: row_index[6:0], midline_col[14:7], top_row[21:15]; tlast: last_row
// m_axis    out        tdata: steer_err[7:0] (signed); tuser: no_weight
// cfg       in         cfg_index: register index; cfg_data: write data
//
// A row that does not end the frame is accepted without a stall. After a last
// row's beat the input stalls through the product state, the numerator state,
// the divide state (21 quotient bits, one per cycle, then the done flag) and
// the finishing state; a frame with zero weight skips the divider. The
// finishing state waits while a previous result is still held in the output
// register. Reset is synchronous and loads the control, configuration and
// state registers at once; there is no clearing pass.

module steering_error_weighted_centroid (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // row_index[6:0], midline_col[14:7], top_row[21:15], zero pad [23:22]
    input  logic [23:0]                       s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // steer_err[7:0]
    output logic [7:0]                        m_axis_tdata,
    // no_weight[0]
    output logic                              m_axis_tuser,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [swc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [swc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import swc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t               state_reg, state_next;
    logic [COL_W-1:0]     center_reg;
    logic [LIM_W-1:0]     limit_reg;
    logic [LIM_W-1:0]     slew_reg;

    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 neg_reg, neg_next;
    logic                 empty_reg, empty_next;
    logic signed [ERR_W-1:0] prev_reg, prev_next;
    logic                 m_valid_reg, m_valid_next;
    logic [ERR_W-1:0]     m_data_reg, m_data_next;
    logic                 m_user_reg, m_user_next;

    logic [ROW_W-1:0]     in_row;
    logic [COL_W-1:0]     in_col;
    logic [ROW_W-1:0]     in_top;
    logic                 accept;
    logic                 out_free;
    acc_ctrl_t            acc_ctrl;
    logic [SUM_W-1:0]     acc_sum;
    logic [TOTAL_W-1:0]   acc_total;

    logic signed [DVD_W:0] num;
    logic [DVD_W-1:0]     num_mag;
    logic                 div_start;
    logic                 div_done;
    logic [DVD_W-1:0]     div_quot;

    logic [DVD_W-1:0]     q_mag;
    logic [LIM_W-1:0]     clamped;
    logic signed [9:0]    err_w;
    logic signed [9:0]    prev_w;
    logic signed [9:0]    slew_w;
    logic signed [9:0]    diff;
    logic signed [9:0]    final_w;

    assign in_row = s_axis_tdata[6:0];
    assign in_col = s_axis_tdata[14:7];
    assign in_top = s_axis_tdata[21:15];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg <= CENTER_RESET;
            limit_reg  <= LIMIT_RESET;
            slew_reg   <= SLEW_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_CENTER: center_reg <= cfg_data[COL_W-1:0];
                REG_LIMIT:  limit_reg  <= cfg_data[LIM_W-1:0];
                REG_SLEW:   slew_reg   <= cfg_data[LIM_W-1:0];
                default:    ;
            endcase
        end
    end

    assign acc_ctrl.acc_en = accept && (in_row > in_top);
    assign acc_ctrl.clear  = (state_reg == ST_FIN) && out_free;

    swc_accum u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (acc_ctrl),
        .row_index   (in_row),
        .midline_col (in_col),
        .sum         (acc_sum),
        .total       (acc_total)
    );

    // Numerator weighted_sum - center*total, split into sign and magnitude
    // so the divider truncates toward zero.
    assign num     = $signed({{(DVD_W-SUM_W+1){1'b0}}, acc_sum})
                   - $signed({2'b00, prod_reg});
    assign num_mag = num[DVD_W] ? DVD_W'(-num) : num[DVD_W-1:0];
    assign div_start = (state_reg == ST_START) && (acc_total != '0);

    swc_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_mag),
        .divisor  (acc_total),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Clamp the magnitude, restore the sign, then limit the change.
    always_comb begin
        q_mag   = empty_reg ? DVD_W'(center_reg) : div_quot;
        clamped = (q_mag > DVD_W'(limit_reg)) ? limit_reg : q_mag[LIM_W-1:0];
        err_w   = neg_reg ? -$signed({3'b000, clamped}) : $signed({3'b000, clamped});
        prev_w  = 10'(prev_reg);
        slew_w  = $signed({3'b000, slew_reg});
        diff    = err_w - prev_w;
        if (diff > slew_w) begin
            final_w = prev_w + slew_w;
        end else if (diff < -slew_w) begin
            final_w = prev_w - slew_w;
        end else begin
            final_w = err_w;
        end
    end

    always_comb begin
        state_next   = state_reg;
        prod_next    = prod_reg;
        neg_next     = neg_reg;
        empty_next   = empty_reg;
        prev_next    = prev_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && s_axis_tlast) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = center_reg * acc_total;
                empty_next = (acc_total == '0);
                state_next = ST_START;
            end
            ST_START: begin
                // With no weight the mean is zero, so the error is -center.
                neg_next   = empty_reg ? 1'b1 : num[DVD_W];
                state_next = empty_reg ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    prev_next    = final_w[ERR_W-1:0];
                    m_valid_next = 1'b1;
                    m_data_next  = final_w[ERR_W-1:0];
                    m_user_next  = empty_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            prev_reg    <= prev_next;
            m_valid_reg <= m_valid_next;
        end
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        empty_reg  <= empty_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef SYNTH
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata != 8'h80))
        else $error("steering error out of range");

    a_clear_after_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && out_free) |=> (acc_sum == '0 && acc_total == '0))
        else $error("accumulators not cleared after frame");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> !acc_ctrl.acc_en)
        else $error("row accumulated while dividing");
`endif

endmodule

/* tb/sv/tb_steering_error_weighted_centroid.sv */
`timescale 1ns / 1ps

module tb_steering_error_weighted_centroid;
    import swc_pkg::*;

    typedef struct {
        logic signed [7:0] steer;
        logic              no_weight;
    } steer_result_t;

    // Keeps a bit-exact copy of the frame accumulators and the registers, and
    // holds the steering results that the block still owes.
    class centroid_scoreboard;
        logic [7:0]      center;
        logic [6:0]      err_limit;
        logic [6:0]      slew_lim;
        int unsigned     wsum;
        int unsigned     wtot;
        longint          prev_err;
        steer_result_t   owed_q[$];
        int              errors;

        function new();
            center    = CENTER_RESET;
            err_limit = LIMIT_RESET;
            slew_lim  = SLEW_RESET;
            wsum      = 0;
            wtot      = 0;
            prev_err  = 0;
            errors    = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [7:0] value);
            case (idx)
                REG_CENTER: begin
                    center = value;
                end
                REG_LIMIT: begin
                    err_limit = value[6:0];
                end
                REG_SLEW: begin
                    slew_lim = value[6:0];
                end
                default: begin
                end
            endcase
        endfunction

        // Weight in tenths, looked up per block of ten rows.
        function int unsigned row_weight(bit [6:0] row);
            int unsigned decade_w[12] = '{0, 0, 0, 0, 10, 10, 13, 18, 25, 25, 25, 0};
            if (row >= ROWS) return 0;
            return decade_w[row / 10];
        endfunction

        function void note_row(bit [6:0] row, bit [7:0] col, bit [6:0] top, bit last);
            int unsigned   w;
            int unsigned   s;
            int unsigned   t;
            longint        num;
            longint        err;
            longint        lim;
            longint        slew;
            steer_result_t res;
            if (row > top) begin
                w = row_weight(row);
                s = wsum + w * col;
                t = wtot + w;
                wsum = (s > (1 << SUM_W) - 1) ? (1 << SUM_W) - 1 : s;
                wtot = (t > (1 << TOTAL_W) - 1) ? (1 << TOTAL_W) - 1 : t;
            end
            if (!last) return;
            res.no_weight = (wtot == 0);
            if (wtot == 0) begin
                err = -longint'(center);
            end else begin
                num = longint'(wsum) - longint'(center) * longint'(wtot);
                // Signed division truncates toward zero.
                err = num / longint'(wtot);
            end
            lim = err_limit;
            if (err > lim) err = lim;
            if (err < -lim) err = -lim;
            slew = slew_lim;
            if (err - prev_err > slew) err = prev_err + slew;
            if (err - prev_err < -slew) err = prev_err - slew;
            prev_err = err;
            wsum = 0;
            wtot = 0;
            res.steer = err[7:0];
            owed_q.push_back(res);
        endfunction

        function void check_result(logic [7:0] data, logic user);
            steer_result_t exp_res;
            if (owed_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: steer %0d no_weight %b",
                             $signed(data), user);
                return;
            end
            exp_res = owed_q.pop_front();
            if (data !== exp_res.steer || user !== exp_res.no_weight) begin
                errors++;
                if (errors <= 10)
                    $display({"result mismatch: expected steer %0d no_weight %b, ",
                              "got steer %0d no_weight %b"},
                             exp_res.steer, exp_res.no_weight, $signed(data), user);
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit gaps_on = 1'b1;
    centroid_scoreboard sb = new();

    steering_error_weighted_centroid dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_steering_error_weighted_centroid failed");
        $finish;
    end

    // Result side: values read right after the edge are the ones the edge saw.
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid === 1'b1 && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
            m_axis_tready <= gaps_on ? ($urandom_range(0, 99) >= 6) : 1'b1;
        end
    end

    task automatic send_row(bit [6:0] row, bit [7:0] col, bit [6:0] top, bit last);
        while (gaps_on && $urandom_range(0, 99) < 6) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, top, col, row};
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (s_axis_tready !== 1'b1) @(posedge aclk);
        sb.note_row(row, col, top, last);
    endtask

    task automatic set_config(logic [7:0] center, logic [6:0] limit, logic [6:0] slew);
        cfg_reg_t   order[3] = '{REG_CENTER, REG_LIMIT, REG_SLEW};
        logic [7:0] value[3];
        value[0] = center;
        value[1] = {1'b0, limit};
        value[2] = {1'b0, slew};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= value[i];
            @(posedge aclk);
            while (cfg_ready !== 1'b1) @(posedge aclk);
            sb.write_reg(order[i], value[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // A plausible frame: fixed top row, rows climbing from the bottom of the
    // image, midline scattered around one column.
    task automatic track_frame(output int count);
        int       pick;
        int       r;
        int       c;
        int       base;
        int       n;
        bit [6:0] top;
        pick = $urandom_range(0, 99);
        if (pick < 70) top = 7'($urandom_range(30, 100));
        else if (pick < 85) top = 7'd0;
        else top = 7'($urandom_range(100, 127));
        n    = $urandom_range(1, 30);
        r    = $urandom_range(100, 127);
        base = $urandom_range(0, 159);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                c = $urandom_range(0, 255);
            end else begin
                c = base + $urandom_range(0, 30) - 15;
                if (c < 0) c = 0;
                if (c > 255) c = 255;
            end
            send_row(r[6:0], c[7:0], top, i == n - 1);
            r = r - $urandom_range(1, 5);
            if (r < 0) r = $urandom_range(0, 127);
        end
        count = n;
    endtask

    // Enough repeats of one heavy row to saturate the weight total, and with col 255 the weighted sum too.
    task automatic saturating_frame(bit [7:0] col);
        for (int i = 0; i < 170; i++)
            send_row(7'd100, col, 7'd0, i == 169);
    endtask

    task automatic random_rows(int target);
        int sent;
        int k;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(0, 99) < 80) begin
                track_frame(k);
                sent += k;
            end else begin
                send_row(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                         7'($urandom_range(0, 127)), $urandom_range(0, 4) == 0);
                sent++;
            end
        end
        // Close any open frame so the next settings start clean.
        track_frame(k);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        // Every owed result has been checked here; the block then idles before the next settings.
        repeat (40) @(posedge aclk);
    endtask

    initial begin
        int edge_rows[13] = '{39, 40, 59, 60, 69, 70, 79, 80, 109, 110, 119, 120, 127};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero weight frame.
        send_row(7'd0, 8'd0, 7'd0, 1'b1);
        // Every band boundary, including rows past the image.
        foreach (edge_rows[i])
            send_row(7'(edge_rows[i]), (i % 2) ? 8'd255 : 8'd0, 7'd0, i == 12);
        // Row not below the top row, and rows beyond the image.
        send_row(7'd100, 8'd255, 7'd127, 1'b1);
        send_row(7'd127, 8'd255, 7'd126, 1'b1);
        // Large errors both ways, held back by the clamp and the slew limit.
        send_row(7'd85, 8'd255, 7'd84, 1'b1);
        send_row(7'd85, 8'd0, 7'd0, 1'b0);
        send_row(7'd90, 8'd0, 7'd0, 1'b1);
        send_row(7'd50, 8'd159, 7'd49, 1'b1);
        // Small negative quotient that must truncate to zero.
        send_row(7'd50, 8'd79, 7'd0, 1'b0);
        send_row(7'd60, 8'd80, 7'd0, 1'b1);
        random_rows(65);
        drain();

        for (int phase = 1; phase < 6; phase++) begin
            case (phase)
                1: set_config(8'd0, 7'd127, 7'd127);
                2: set_config(8'd159, 7'd0, 7'd0);
                3: set_config(8'd255, 7'd127, 7'd1);
                default: set_config(8'($urandom_range(0, 159)), 7'($urandom_range(0, 127)),
                                    7'($urandom_range(0, 127)));
            endcase
            gaps_on = (phase != 2);
            if (phase == 1) begin
                saturating_frame(8'd255);
                saturating_frame(8'd0);
            end
            random_rows(65);
            drain();
        end

        if (sb.errors == 0)
            $display("tb_steering_error_weighted_centroid passed");
        else
            $display("tb_steering_error_weighted_centroid failed");
        $finish;
    end

endmodule
